[hdl/cbd_pkg.sv]
// ----------------------------------------------------------------------------
// cbd_pkg: shared types and constants of the ring-buffer deque
// Capacity, index widths, operation codes and the control structs that
// pass between the index controller and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cbd_pkg;

	localparam int DEPTH  = 1024;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	localparam logic signed [WORD_W-1:0] EMPTY_VALUE = -32'sd1;

	typedef enum logic [1:0] {
		ACT_PUSH_FRONT = 2'd0,
		ACT_POP_FRONT  = 2'd1,
		ACT_PUSH_BACK  = 2'd2,
		ACT_POP_BACK   = 2'd3
	} action_t;

	// At most one storage access per operation.
	typedef struct packed {
		logic              we;
		logic              re;
		logic [IDX_W-1:0]  addr;
		logic [WORD_W-1:0] wdata;
	} mem_req_t;

	// Status of one operation, carried to the output stage.
	typedef struct packed {
		logic use_ram;
		logic was_empty;
		logic push_refused;
	} res_t;

	function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] r;
		if (idx == IDX_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = idx + IDX_W'(1);
		end
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] r;
		if (idx == '0) begin
			r = IDX_W'(DEPTH - 1);
		end else begin
			r = idx - IDX_W'(1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/cbd_ram.sv]
// ----------------------------------------------------------------------------
// cbd_ram: generic single-port synchronous RAM
// One write or one read per cycle; read data is registered and holds
// its value until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module cbd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0]                       wdata,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

[hdl/cbd_ctrl.sv]
// ----------------------------------------------------------------------------
// cbd_ctrl: front/back index and count controller
// Decides each operation, steps the indices and count, and issues the
// storage access for the word pushed or popped.
// ----------------------------------------------------------------------------
`default_nettype none

module cbd_ctrl
	import cbd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire logic [1:0]          action,
	input  wire logic [WORD_W-1:0]   data_value,
	output mem_req_t                 mem_req,
	output res_t                     result
);

	logic [IDX_W-1:0] front_q, back_q, front_d, back_d;
	logic [CNT_W-1:0] count_q, count_d;
	action_t          act;
	logic             is_push, empty, full;

	assign act   = action_t'(action);
	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));

	always_comb begin
		is_push = act inside {ACT_PUSH_FRONT, ACT_PUSH_BACK};
		front_d = front_q;
		back_d  = back_q;
		count_d = count_q;
		mem_req = '{we: 1'b0, re: 1'b0, addr: front_q, wdata: data_value};
		result  = '{use_ram: 1'b0, was_empty: 1'b0, push_refused: 1'b0};

		if (is_push) begin
			result.push_refused = full;
		end else begin
			result.was_empty = empty;
			result.use_ram   = !empty;
		end

		case (act)
			ACT_PUSH_FRONT: begin
				if (!full) begin
					front_d = empty ? front_q : step_down(front_q);
					count_d = count_q + CNT_W'(1);
					mem_req.we   = 1'b1;
					mem_req.addr = front_d;
				end
			end
			ACT_PUSH_BACK: begin
				if (!full) begin
					back_d  = empty ? back_q : step_up(back_q);
					count_d = count_q + CNT_W'(1);
					mem_req.we   = 1'b1;
					mem_req.addr = back_d;
				end
			end
			ACT_POP_FRONT: begin
				if (!empty) begin
					count_d = count_q - CNT_W'(1);
					mem_req.re   = 1'b1;
					mem_req.addr = front_q;
					if (count_q != CNT_W'(1)) begin
						front_d = step_up(front_q);
					end
				end
			end
			ACT_POP_BACK: begin
				if (!empty) begin
					count_d = count_q - CNT_W'(1);
					mem_req.re   = 1'b1;
					mem_req.addr = back_q;
					if (count_q != CNT_W'(1)) begin
						back_d = step_down(back_q);
					end
				end
			end
			default: begin
			end
		endcase

		if (!take) begin
			mem_req.we = 1'b0;
			mem_req.re = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else if (take) begin
			front_q <= front_d;
			back_q  <= back_d;
			count_q <= count_d;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds capacity");

	a_ends_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= CNT_W'(1)) |-> (front_q == back_q))
		else $error("front and back differ with at most one entry");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(take && mem_req.re) |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("pop did not decrement the count");

	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.we && mem_req.re))
		else $error("read and write issued together");

endmodule

`default_nettype wire

[hdl/circular_buffer_deque_core.sv]
// ----------------------------------------------------------------------------
// circular_buffer_deque_core: double-ended queue of 32-bit words
// Fixed-capacity deque in a ring store, with push and pop at both ends.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one word per operation:
// an action code (push front, pop front, push back, pop back) and the
// data word to push, which pops ignore. Every accepted word produces
// exactly one result word on the output channel (out_valid/out_ready):
// the popped value, or -1 with was_empty set for a pop of an empty queue,
// or 0 for a push, with push_refused set when the queue was full.
// The result is valid in the cycle after the input is accepted, its popped
// word coming straight from the registered read port of the single-port
// ring memory. The core takes one operation per cycle while the receiver
// keeps up, bounded by that one memory port, which each operation uses at
// most once. A push followed directly by a pop of the same entry needs no
// forwarding, since the write lands at the edge before the read.
// When the receiver stalls, the result stage holds (the memory read data
// holds since no new read is issued) and in_ready falls until it drains.
// Reset clears the indices, the count and the result valid flag; memory
// contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_buffer_deque_core
	import cbd_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [1:0]                action,
	input  wire logic signed [WORD_W-1:0]  data_value,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic signed [WORD_W-1:0]       out_value,
	output logic                           was_empty,
	output logic                           push_refused
);

	logic              take;
	logic              valid_s1;
	res_t              res_s1;
	res_t              result;
	mem_req_t          mem_req;
	logic [WORD_W-1:0] rd_data;

	// The result stage can take a new word whenever it is empty or its
	// current word leaves in this cycle.
	assign in_ready = !valid_s1 || out_ready;
	assign take     = in_valid && in_ready;

	cbd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.action     (action),
		.data_value (data_value),
		.mem_req    (mem_req),
		.result     (result)
	);

	cbd_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (mem_req.we),
		.re    (mem_req.re),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s1 <= result;
		end
	end

	// Popped words come from the memory's output register; everything
	// else is a fixed value chosen by the flags.
	always_comb begin
		if (res_s1.use_ram) begin
			out_value = $signed(rd_data);
		end else if (res_s1.was_empty) begin
			out_value = EMPTY_VALUE;
		end else begin
			out_value = '0;
		end
	end

	assign out_valid    = valid_s1;
	assign was_empty    = res_s1.was_empty;
	assign push_refused = res_s1.push_refused;

endmodule

`default_nettype wire
